>>> rtl/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and helpers for the dual serial controller
// register port.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // Receive FIFO depth per channel (2..256)
    localparam int RX_FIFO_DEPTH = 4;
    localparam int RX_IDX_W      = $clog2(RX_FIFO_DEPTH);
    localparam int RX_CNT_W      = $clog2(RX_FIFO_DEPTH + 1);
    localparam int RX_ADDR_W     = RX_IDX_W + 1;
    localparam int RX_RAM_DEPTH  = 2 ** RX_ADDR_W;

    // Time-constant register file: RR12..RR15 of both channels
    localparam int REGF_ADDR_W   = 3;
    localparam int REGF_DEPTH    = 2 ** REGF_ADDR_W;

    // Register numbers
    localparam logic [3:0] REG_CMD    = 4'd0;
    localparam logic [3:0] REG_IMODE  = 4'd1;
    localparam logic [3:0] REG_VECTOR = 4'd2;
    localparam logic [3:0] REG_IPEND  = 4'd3;
    localparam logic [3:0] REG_MIC    = 4'd9;

    // WR0 command codes
    localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
    localparam logic [2:0] CMD_RESET_EXT  = 3'd2;
    localparam logic [2:0] CMD_RESET_TX   = 3'd5;
    localparam logic [2:0] CMD_ERR_RESET  = 3'd6;
    localparam logic [2:0] CMD_RESET_IUS  = 3'd7;

    // WR9 reset selector
    localparam logic [1:0] RST_NONE  = 2'b00;
    localparam logic [1:0] RST_CHANB = 2'b01;
    localparam logic [1:0] RST_CHANA = 2'b10;
    localparam logic [1:0] RST_WORLD = 2'b11;

    localparam logic [7:0] RR0_TX_EMPTY = 8'h04;
    localparam logic [7:0] RR1_ALL_SENT = 8'h01;
    localparam logic [7:0] RR15_MASK    = 8'hFA;

    typedef enum logic [2:0] {
        OP_READ_CTL   = 3'd0,
        OP_READ_DATA  = 3'd1,
        OP_WRITE_CTL  = 3'd2,
        OP_WRITE_DATA = 3'd3,
        OP_RX_BYTE    = 3'd4,
        OP_ACK        = 3'd5,
        OP_UPDATE     = 3'd6
    } op_t;

    // Where the read byte of a result comes from
    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_FIFO  = 2'd1,
        SRC_REGF  = 2'd2,
        SRC_LAST  = 2'd3
    } src_t;

    // Result stage contents handed from core to output side
    typedef struct packed {
        logic       ch;
        src_t       src;
        logic [7:0] value;
        logic       irq;
        logic       tx_valid;
        logic       tx_channel;
        logic [7:0] tx_byte;
        logic       drop;
    } res_t;

    // Pending bit masks; channel 1 is A
    function automatic logic [5:0] bit_stat(input logic ch);
        return ch ? 6'h08 : 6'h01;
    endfunction

    function automatic logic [5:0] bit_tx(input logic ch);
        return ch ? 6'h10 : 6'h02;
    endfunction

    function automatic logic [5:0] bit_rx(input logic ch);
        return ch ? 6'h20 : 6'h04;
    endfunction

endpackage

>>> rtl/dsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dsc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_core
// Register pointer, interrupt logic, FIFO control and the two RAMs (receive
// store and RR12..RR15). Each accepted beat updates state and loads the
// result stage; RAM read data is registered at the same edge and arrives alongside it.
// ----------------------------------------------------------------------------
module dsc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  dsc_pkg::op_t         op,
    input  logic                 channel,
    input  logic [7:0]           value,
    output dsc_pkg::res_t        res,
    output logic [7:0]           fifo_rdata,
    output logic [7:0]           regf_rdata
);
    import dsc_pkg::*;

    logic [3:0]          ptr_reg, ptr_next;
    logic [7:0]          wr1_reg [2];
    logic [7:0]          wr1_next [2];
    logic [RX_CNT_W-1:0] cnt_reg [2];
    logic [RX_CNT_W-1:0] cnt_next [2];
    logic [RX_IDX_W-1:0] widx_reg [2];
    logic [RX_IDX_W-1:0] widx_next [2];
    logic [RX_IDX_W-1:0] ridx_reg [2];
    logic [RX_IDX_W-1:0] ridx_next [2];
    logic [5:0]          pend_reg, pend_next;
    logic [7:0]          vector_reg, vector_next;
    logic                me_reg, me_next;
    logic                sh_reg, sh_next;
    logic                irq_reg, irq_next;
    logic [REGF_DEPTH-1:0] rfv_reg, rfv_next;
    res_t                res_reg, res_next;

    logic                  fifo_we, fifo_re;
    logic [RX_ADDR_W-1:0]  fifo_waddr, fifo_raddr;
    logic                  regf_we, regf_re;
    logic [REGF_ADDR_W-1:0] regf_addr;
    logic [7:0]            regf_wdata;

    logic [1:0] rst_ch;
    logic       world;
    logic       do_eval;
    logic       ch;
    logic [2:0] cmd;
    logic [2:0] code;

    // Pending-source code for the modified vector
    always_comb
    begin
        if (pend_reg[3])      code = 3'd5;
        else if (pend_reg[5]) code = 3'd6;
        else if (pend_reg[4]) code = 3'd4;
        else if (pend_reg[0]) code = 3'd1;
        else if (pend_reg[2]) code = 3'd2;
        else if (pend_reg[1]) code = 3'd0;
        else                  code = 3'd3;
    end

    // Next-state logic for one beat
    always_comb
    begin
        ch          = channel;
        cmd         = value[5:3];
        ptr_next    = ptr_reg;
        wr1_next    = wr1_reg;
        cnt_next    = cnt_reg;
        widx_next   = widx_reg;
        ridx_next   = ridx_reg;
        pend_next   = pend_reg;
        vector_next = vector_reg;
        me_next     = me_reg;
        sh_next     = sh_reg;
        irq_next    = irq_reg;
        rfv_next    = rfv_reg;
        res_next    = res_reg;
        rst_ch      = 2'b00;
        world       = 1'b0;
        do_eval     = 1'b0;
        fifo_we     = 1'b0;
        fifo_re     = 1'b0;
        fifo_waddr  = {ch, widx_reg[ch]};
        fifo_raddr  = {ch, ridx_reg[ch]};
        regf_we     = 1'b0;
        regf_re     = 1'b0;
        regf_addr   = {ch, ptr_reg[1:0]};
        regf_wdata  = (ptr_reg[1:0] == 2'b11) ? (value & RR15_MASK) : value;

        if (accept)
        begin
            res_next.ch         = ch;
            res_next.src        = SRC_CONST;
            res_next.value      = 8'h00;
            res_next.tx_valid   = 1'b0;
            res_next.tx_channel = 1'b0;
            res_next.tx_byte    = 8'h00;
            res_next.drop       = 1'b0;

            case (op)
                OP_READ_CTL:
                begin
                    ptr_next = 4'd0;
                    if (ptr_reg == REG_CMD)
                        res_next.value = RR0_TX_EMPTY | {7'd0, cnt_reg[ch] != '0};
                    else if (ptr_reg == REG_IMODE)
                        res_next.value = RR1_ALL_SENT;
                    else if (ptr_reg == REG_VECTOR)
                    begin
                        if (ch)
                            res_next.value = vector_reg;
                        else if (sh_reg)
                            res_next.value = (vector_reg & 8'h8F) | {1'b0, code, 4'd0};
                        else
                            res_next.value = (vector_reg & 8'hF1) | {4'd0, code, 1'b0};
                    end
                    else if (ptr_reg == REG_IPEND)
                        res_next.value = ch ? {2'b00, pend_reg} : 8'h00;
                    else if (ptr_reg[3:2] == 2'b11)
                    begin
                        regf_re = 1'b1;
                        if (rfv_reg[regf_addr])
                            res_next.src = SRC_REGF;
                    end
                end

                OP_READ_DATA:
                begin
                    if (cnt_reg[ch] != '0)
                    begin
                        fifo_re      = 1'b1;
                        res_next.src = SRC_FIFO;
                        ridx_next[ch] = (ridx_reg[ch] == RX_IDX_W'(RX_FIFO_DEPTH - 1)) ?
                                        '0 : ridx_reg[ch] + 1'b1;
                        cnt_next[ch] = cnt_reg[ch] - 1'b1;
                    end
                    else
                    begin
                        res_next.src = SRC_LAST;
                    end
                    if (cnt_next[ch] == '0)
                    begin
                        pend_next = pend_next & ~bit_rx(ch);
                        do_eval   = 1'b1;
                    end
                end

                OP_WRITE_CTL:
                begin
                    ptr_next = 4'd0;
                    if (ptr_reg == REG_CMD)
                    begin
                        ptr_next = {cmd == CMD_POINT_HIGH, value[2:0]};
                        case (cmd)
                            CMD_RESET_EXT:
                            begin
                                pend_next = pend_reg & ~bit_stat(ch);
                                do_eval   = 1'b1;
                            end
                            CMD_RESET_TX:
                            begin
                                pend_next = pend_reg & ~bit_tx(ch);
                                do_eval   = 1'b1;
                            end
                            CMD_RESET_IUS: do_eval = 1'b1;
                            CMD_ERR_RESET: ; // RR1 error bits never set
                            default: ;
                        endcase
                    end
                    else if (ptr_reg == REG_MIC)
                    begin
                        do_eval = 1'b1;
                        unique case (value[7:6])
                            RST_WORLD:
                            begin
                                rst_ch = 2'b11;
                                world  = 1'b1;
                            end
                            RST_CHANA: rst_ch = 2'b10;
                            RST_CHANB: rst_ch = 2'b01;
                            RST_NONE:
                            begin
                                me_next = value[3];
                                sh_next = value[4];
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        do_eval = 1'b1;
                        if (ptr_reg == REG_IMODE)
                            wr1_next[ch] = value;
                        else if (ptr_reg == REG_VECTOR)
                            vector_next = value;
                        else if (ptr_reg[3:2] == 2'b11)
                        begin
                            regf_we             = 1'b1;
                            rfv_next[regf_addr] = 1'b1;
                        end
                    end
                end

                OP_WRITE_DATA:
                begin
                    res_next.tx_valid   = 1'b1;
                    res_next.tx_channel = ch;
                    res_next.tx_byte    = value;
                    if (wr1_reg[ch][1])
                    begin
                        pend_next = pend_reg | bit_tx(ch);
                        do_eval   = 1'b1;
                    end
                end

                OP_RX_BYTE:
                begin
                    if (cnt_reg[ch] == RX_CNT_W'(RX_FIFO_DEPTH))
                        res_next.drop = 1'b1;
                    else
                    begin
                        fifo_we       = 1'b1;
                        widx_next[ch] = (widx_reg[ch] == RX_IDX_W'(RX_FIFO_DEPTH - 1)) ?
                                        '0 : widx_reg[ch] + 1'b1;
                        cnt_next[ch]  = cnt_reg[ch] + 1'b1;
                    end
                    if (wr1_reg[ch][4:3] != 2'b00)
                    begin
                        pend_next = pend_reg | bit_rx(ch);
                        do_eval   = 1'b1;
                    end
                end

                OP_ACK: irq_next = 1'b0;

                OP_UPDATE:
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        if (cnt_reg[c] != '0 && wr1_reg[c][4:3] != 2'b00)
                            pend_next = pend_next | bit_rx(c[0]);
                    end
                    do_eval = 1'b1;
                end

                default: ;
            endcase

            // Channel resets from WR9
            for (int c = 0; c < 2; c++)
            begin
                if (rst_ch[c])
                begin
                    wr1_next[c]  = 8'h00;
                    cnt_next[c]  = '0;
                    widx_next[c] = '0;
                    ridx_next[c] = '0;
                    rfv_next[c*4 +: 4] = 4'b0000;
                    pend_next = pend_next & ~(bit_stat(c[0]) | bit_tx(c[0]) | bit_rx(c[0]));
                end
            end

            // World reset and IRQ evaluation
            if (world)
            begin
                ptr_next  = 4'd0;
                me_next   = 1'b0;
                sh_next   = 1'b0;
                pend_next = 6'd0;
                irq_next  = 1'b0;
            end
            else if (do_eval)
            begin
                irq_next = (pend_next != 6'd0) && me_next;
            end

            res_next.irq = irq_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= 4'd0;
            wr1_reg    <= '{default: 8'h00};
            cnt_reg    <= '{default: '0};
            widx_reg   <= '{default: '0};
            ridx_reg   <= '{default: '0};
            pend_reg   <= 6'd0;
            vector_reg <= 8'h00;
            me_reg     <= 1'b0;
            sh_reg     <= 1'b0;
            irq_reg    <= 1'b0;
            rfv_reg    <= '0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            wr1_reg    <= wr1_next;
            cnt_reg    <= cnt_next;
            widx_reg   <= widx_next;
            ridx_reg   <= ridx_next;
            pend_reg   <= pend_next;
            vector_reg <= vector_next;
            me_reg     <= me_next;
            sh_reg     <= sh_next;
            irq_reg    <= irq_next;
            rfv_reg    <= rfv_next;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

    // Receive store, both channels
    dsc_ram #(
        .WIDTH (8),
        .DEPTH (RX_RAM_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (value),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // RR12..RR15, both channels
    dsc_ram #(
        .WIDTH (8),
        .DEPTH (REGF_DEPTH)
    ) u_regf_ram (
        .clk   (clk),
        .we    (regf_we),
        .waddr (regf_addr),
        .wdata (regf_wdata),
        .re    (regf_re),
        .raddr (regf_addr),
        .rdata (regf_rdata)
    );

endmodule

>>> rtl/dual_serial_controller_regs.sv
`timescale 1ns / 1ps
// A result beat is offered in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the output is ready; the result register and RAM read ports are
// held while the output stalls, and a new beat enters as the old one leaves.
// Reset: asynchronous, active low; clears pointer, FIFO counts, pending bits
// and register-file valid bits at once. No clearing pass.
// ----------------------------------------------------------------------------
// dual_serial_controller_regs
// Two-channel serial controller register port: bus accesses, received bytes,
// acknowledge and update ticks in; one result beat out per input beat.
// ----------------------------------------------------------------------------
module dual_serial_controller_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // value[7:0]
    input  logic [3:0]  s_axis_tuser,   // op[2:0], channel[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // read_value[7:0], irq[8], tx_valid[9],
                                        // tx_channel[10], tx_byte[18:11],
                                        // rx_dropped[19], zero[23:20]
);
    import dsc_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] last_rx_reg [2];
    logic [7:0] last_rx_next [2];
    logic       accept;
    logic       leave;
    res_t       res;
    logic [7:0] fifo_rdata;
    logic [7:0] regf_rdata;
    logic [7:0] read_value;

    // Handshake
    assign leave         = valid_reg && m_axis_tready;
    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign valid_next    = accept ? 1'b1 : (leave ? 1'b0 : valid_reg);

    dsc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op_t'(s_axis_tuser[2:0])),
        .channel    (s_axis_tuser[3]),
        .value      (s_axis_tdata),
        .res        (res),
        .fifo_rdata (fifo_rdata),
        .regf_rdata (regf_rdata)
    );

    // Read byte select
    always_comb
    begin
        case (res.src)
            SRC_FIFO: read_value = fifo_rdata;
            SRC_REGF: read_value = regf_rdata;
            SRC_LAST: read_value = last_rx_reg[res.ch];
            default:  read_value = res.value;
        endcase
    end

    // Last byte taken from each FIFO
    always_comb
    begin
        last_rx_next = last_rx_reg;
        if (leave && res.src == SRC_FIFO)
            last_rx_next[res.ch] = fifo_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            last_rx_reg <= '{default: 8'h00};
        end
        else
        begin
            valid_reg   <= valid_next;
            last_rx_reg <= last_rx_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, res.drop, res.tx_byte, res.tx_channel,
                            res.tx_valid, res.irq, read_value};

endmodule

>>> tb/dual_serial_controller_regs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_serial_controller_regs_tb
// Drives register accesses, received bytes, acks and update ticks into the
// serial controller port, models the register state alongside it and checks
// every result beat field by field, under bursty input and stalled output.
// ----------------------------------------------------------------------------
module dual_serial_controller_regs_tb;
    import dsc_pkg::*;

    typedef struct packed {
        logic [2:0] op;
        logic       ch;
        logic [7:0] value;
    } access_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic       txv;
        logic       txc;
        logic [7:0] txb;
        logic       drop;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    access_t  pending_q[$];
    outcome_t expected_q[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       hold_req = 1'b0;
    bit       feeding_done = 1'b0;

    // shadow controller state
    logic [3:0] m_ptr;
    logic [7:0] m_wr [2][16];
    logic [7:0] m_rr [2][16];
    logic [7:0] m_fifo [2][RX_FIFO_DEPTH];
    int         m_cnt [2];
    int         m_wi [2];
    int         m_ri [2];
    logic [7:0] m_last [2];
    logic [5:0] m_pend;
    logic [7:0] m_vec;
    logic       m_me, m_sh, m_vis, m_irq;

    dual_serial_controller_regs uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] pb_stat(input logic c);
        return c ? 6'h08 : 6'h01;
    endfunction
    function automatic logic [5:0] pb_tx(input logic c);
        return c ? 6'h10 : 6'h02;
    endfunction
    function automatic logic [5:0] pb_rx(input logic c);
        return c ? 6'h20 : 6'h04;
    endfunction

    task automatic shadow_reset();
        m_ptr = '0;
        for (int c = 0; c < 2; c++)
        begin
            for (int r = 0; r < 16; r++)
            begin
                m_wr[c][r] = '0;
                m_rr[c][r] = '0;
            end
            m_rr[c][0] = 8'h04;
            m_rr[c][1] = 8'h01;
            m_cnt[c] = 0; m_wi[c] = 0; m_ri[c] = 0; m_last[c] = '0;
        end
        m_pend = '0; m_vec = '0; m_me = 0; m_sh = 0; m_vis = 0; m_irq = 0;
    endtask

    function automatic void update_irq();
        m_irq = (m_pend != 0) && m_me;
    endfunction

    function automatic void clear_channel(input logic c);
        for (int r = 1; r < 16; r++)
        begin
            m_wr[c][r] = '0;
            m_rr[c][r] = '0;
        end
        m_rr[c][0] = 8'h04;
        m_rr[c][1] = 8'h01;
        m_cnt[c] = 0; m_wi[c] = 0; m_ri[c] = 0;
        m_pend &= ~(pb_stat(c) | pb_tx(c) | pb_rx(c));
    endfunction

    function automatic logic [7:0] vector_read(input logic c);
        logic [2:0] code;
        if (c) return m_vec;
        if (m_pend[3]) code = 3'd5;
        else if (m_pend[5]) code = 3'd6;
        else if (m_pend[4]) code = 3'd4;
        else if (m_pend[0]) code = 3'd1;
        else if (m_pend[2]) code = 3'd2;
        else if (m_pend[1]) code = 3'd0;
        else code = 3'd3;
        if (m_sh) return (m_vec & 8'h8f) | {1'b0, code, 4'b0};
        return (m_vec & 8'hf1) | {4'b0, code, 1'b0};
    endfunction

    function automatic void control_write(input logic c, input logic [7:0] v);
        logic [3:0] r;
        logic [2:0] cmd;
        r = m_ptr;
        m_wr[c][r] = v;
        if (r == REG_CMD)
        begin
            cmd = v[5:3];
            if (cmd == CMD_RESET_EXT) begin m_pend &= ~pb_stat(c); update_irq(); end
            else if (cmd == CMD_RESET_TX) begin m_pend &= ~pb_tx(c); update_irq(); end
            else if (cmd == CMD_ERR_RESET) m_rr[c][1] &= 8'h0f;
            else if (cmd == CMD_RESET_IUS) update_irq();
            m_ptr = (cmd == CMD_POINT_HIGH) ? {1'b1, v[2:0]} : {1'b0, v[2:0]};
            return;
        end
        if (r == REG_MIC)
        begin
            case (v[7:6])
                RST_WORLD:
                begin
                    clear_channel(0); clear_channel(1);
                    m_me = 0; m_vis = 0; m_sh = 0; m_pend = '0; m_irq = 0;
                end
                RST_CHANA: begin clear_channel(1); update_irq(); end
                RST_CHANB: begin clear_channel(0); update_irq(); end
                default:
                begin
                    m_me = v[3]; m_vis = v[0]; m_sh = v[4];
                    update_irq();
                end
            endcase
            m_ptr = '0;
            return;
        end
        if (r == REG_VECTOR)
        begin
            m_vec = v; m_rr[0][2] = v; m_rr[1][2] = v;
        end
        else if (r >= 12 && r <= 14) m_rr[c][r] = v;
        else if (r == 15) m_rr[c][r] = v & ~8'h05;
        m_ptr = '0;
        update_irq();
    endfunction

    function automatic outcome_t predict_outcome(input access_t a);
        outcome_t o;
        logic c;
        logic [3:0] r;
        o = '0;
        c = a.ch;
        case (a.op)
            OP_READ_CTL:
            begin
                r = m_ptr;
                if (r == 0)
                begin
                    m_rr[c][0][0] = (m_cnt[c] > 0);
                    m_rr[c][0][2] = 1'b1;
                    o.rd = m_rr[c][0];
                end
                else if (r == 2) o.rd = vector_read(c);
                else if (r == 3) o.rd = c ? {2'b0, m_pend} : 8'h00;
                else o.rd = m_rr[c][r];
                m_ptr = '0;
            end
            OP_READ_DATA:
            begin
                if (m_cnt[c] > 0)
                begin
                    m_last[c] = m_fifo[c][m_ri[c]];
                    m_ri[c] = (m_ri[c] + 1) % RX_FIFO_DEPTH;
                    m_cnt[c]--;
                end
                if (m_cnt[c] == 0)
                begin
                    m_rr[c][0][0] = 1'b0;
                    m_pend &= ~pb_rx(c);
                    update_irq();
                end
                o.rd = m_last[c];
            end
            OP_WRITE_CTL: control_write(c, a.value);
            OP_WRITE_DATA:
            begin
                o.txv = 1; o.txc = c; o.txb = a.value;
                m_rr[c][1][0] = 1'b1;
                m_rr[c][0][2] = 1'b1;
                if (m_wr[c][1][1]) begin m_pend |= pb_tx(c); update_irq(); end
            end
            OP_RX_BYTE:
            begin
                if (m_cnt[c] >= RX_FIFO_DEPTH) o.drop = 1;
                else
                begin
                    m_fifo[c][m_wi[c]] = a.value;
                    m_wi[c] = (m_wi[c] + 1) % RX_FIFO_DEPTH;
                    m_cnt[c]++;
                end
                m_rr[c][0][0] = 1'b1;
                if (m_wr[c][1] & 8'h18) begin m_pend |= pb_rx(c); update_irq(); end
            end
            OP_ACK: m_irq = 0;
            OP_UPDATE:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (m_cnt[k] > 0)
                    begin
                        m_rr[k][0][0] = 1'b1;
                        if (m_wr[k][1] & 8'h18) m_pend |= pb_rx(k);
                    end
                    else m_rr[k][0][0] = 1'b0;
                end
                update_irq();
            end
            default: ;
        endcase
        o.irq = m_irq;
        return o;
    endfunction

    function automatic access_t mk(input logic [2:0] op, input logic c,
                                   input logic [7:0] v);
        access_t a;
        a.op = op; a.ch = c; a.value = v;
        return a;
    endfunction

    // pointer to a register, then an access to it
    task automatic push_reg_write(input logic c, input logic [3:0] r, input logic [7:0] v);
        if (r != 0)
            pending_q.push_back(mk(OP_WRITE_CTL, c,
                                   r[3] ? {2'b0, CMD_POINT_HIGH, r[2:0]} : {5'b0, r[2:0]}));
        pending_q.push_back(mk(OP_WRITE_CTL, c, v));
    endtask

    task automatic push_reg_read(input logic c, input logic [3:0] r);
        if (r != 0)
            pending_q.push_back(mk(OP_WRITE_CTL, c,
                                   r[3] ? {2'b0, CMD_POINT_HIGH, r[2:0]} : {5'b0, r[2:0]}));
        pending_q.push_back(mk(OP_READ_CTL, c, 8'h00));
    endtask

    // stimulus
    initial
    begin
        logic c;
        int   sel;
        shadow_reset();
        // directed
        push_reg_read(1, 0);
        push_reg_read(0, 1);
        push_reg_write(1, 1, 8'h1a);
        push_reg_write(0, 1, 8'h1a);
        push_reg_write(0, 9, 8'h19);
        push_reg_write(1, 2, 8'hff);
        pending_q.push_back(mk(OP_WRITE_DATA, 1, 8'h00));
        pending_q.push_back(mk(OP_WRITE_DATA, 0, 8'hff));
        for (int i = 0; i < 5; i++) pending_q.push_back(mk(OP_RX_BYTE, 0, 8'(8'h55 + i)));
        push_reg_read(0, 2);
        push_reg_read(1, 3);
        push_reg_read(0, 3);
        pending_q.push_back(mk(OP_ACK, 0, 8'h00));
        pending_q.push_back(mk(OP_UPDATE, 1, 8'h00));
        for (int i = 0; i < 5; i++) pending_q.push_back(mk(OP_READ_DATA, 0, 8'h00));
        push_reg_write(1, 15, 8'hff);
        push_reg_read(1, 15);
        push_reg_write(0, 0, 8'h30);
        push_reg_write(1, 9, 8'hc0);
        // random: mostly well-formed pointer sequences
        for (int i = 0; i < 450; i++)
        begin
            c = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 20) push_reg_write(c, 4'($urandom_range(0, 15)),
                                         (($urandom_range(0, 9) == 0) ? 8'hff : 8'h3f)
                                         & 8'($urandom));
            else if (sel < 35) push_reg_read(c, 4'($urandom_range(0, 15)));
            else if (sel < 38) push_reg_write(c, 9, 8'($urandom));
            else if (sel < 55) pending_q.push_back(mk(OP_RX_BYTE, c, 8'($urandom)));
            else if (sel < 70) pending_q.push_back(mk(OP_READ_DATA, c, 8'($urandom)));
            else if (sel < 80) pending_q.push_back(mk(OP_WRITE_DATA, c, 8'($urandom)));
            else if (sel < 86) pending_q.push_back(mk(OP_ACK, c, 8'($urandom)));
            else if (sel < 92) pending_q.push_back(mk(OP_UPDATE, c, 8'($urandom)));
            else if (sel < 94) pending_q.push_back(mk(3'd7, c, 8'($urandom)));
            else pending_q.push_back(mk(3'($urandom_range(0, 6)), c, 8'($urandom)));
        end
        feeding_done = 1'b1;
    end

    // reset
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // long receiver hold-off once, early in the random part
    initial
    begin
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_req = 1'b1;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0)
        begin
            @(posedge clk);
            hold_left--;
        end
        hold_req = 1'b0;
    end

    // driver: bursts and gaps
    always @(posedge clk)
    begin
        access_t a;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    a = pending_q.pop_front();
                    expected_q.push_back(predict_outcome(a));
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= a.value;
                    s_axis_tuser <= {a.ch, a.op};
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result check
    always @(posedge clk)
    begin
        outcome_t got, want;
        if (rst_n)
        begin
            m_axis_tready <= !hold_req && (($urandom_range(0, 7) > 2) || ($time % 4000 < 800));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.rd = m_axis_tdata[7:0];
                got.irq = m_axis_tdata[8];
                got.txv = m_axis_tdata[9];
                got.txc = m_axis_tdata[10];
                got.txb = m_axis_tdata[18:11];
                got.drop = m_axis_tdata[19];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[23:20] !== 4'h0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp rd=%h irq=%b tx=%b/%b/%h drop=%b, got %h",
                                     want.rd, want.irq, want.txv, want.txc, want.txb,
                                     want.drop, m_axis_tdata);
                    end
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        fork
            begin
                while (!(feeding_done && pending_q.size() == 0 && !s_axis_tvalid
                         && expected_q.size() == 0))
                    @(posedge clk);
                repeat (20) @(posedge clk);
                if (mismatches == 0 && expected_q.size() == 0)
                    $display("dual_serial_controller_regs test passed");
                else
                    $display("dual_serial_controller_regs test failed");
                $finish;
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                $display("dual_serial_controller_regs test failed");
                $finish;
            end
        join
    end

endmodule
